// File: rtl/bpsa_pkg.sv
// ----------------------------------------------------------------------------
// bpsa_pkg - shared types and constants for the boundary pair stats block
// Table geometry, hash constant, operation codes, table word and FSM states.
// ----------------------------------------------------------------------------
package bpsa_pkg;

	// Table geometry (entry count must be a power of two)
	localparam int TBL_ENTRIES = 4096;
	localparam int TBL_AW      = $clog2(TBL_ENTRIES);
	localparam int MAX_PROBES  = 8;
	localparam int PRB_W       = $clog2(MAX_PROBES + 1);

	localparam int LBL_W = 32;
	localparam int KEY_W = 2 * LBL_W;
	localparam int SUM_W = 40;
	localparam int CNT_W = 32;
	localparam int VAL_W = 8;

	localparam logic [63:0] HASH_MUL = 64'h9E37_79B9_7F4A_7C15;

	// Operation codes
	typedef enum logic [2:0] {
		OP_INTERIOR = 3'd0,
		OP_ROW      = 3'd1,
		OP_COLUMN   = 3'd2,
		OP_CORNER   = 3'd3,
		OP_READ     = 3'd4,
		OP_CLEAR    = 3'd5
	} op_t;

	// One table word
	typedef struct packed {
		logic             used;
		logic [KEY_W-1:0] key;
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] count;
	} tbl_word_t;

	localparam int WORD_W = $bits(tbl_word_t);

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_NEXT,
		ST_HASH1,
		ST_HASH2,
		ST_LOOK,
		ST_CHECK
	} state_t;

endpackage

// File: rtl/boundary_pair_stats_accumulator_top.sv
// ----------------------------------------------------------------------------
// boundary_pair_stats_accumulator_top - region pair boundary statistics
// Hashed, linearly probed table of label pairs with saturating sum and count.
// A pixel passes hash, lookup and check for each allowed pair, plus a lookup and
// check per extra probe (up to 8 probes); a read does one lookup and check.
// Clear is a sweep of the table, one word a cycle.
// One item at a time: busy is high from acceptance until the done strobe.
// Reset: a sweep of the whole table clears it, busy high meanwhile.
// ----------------------------------------------------------------------------
module boundary_pair_stats_accumulator_top
	import bpsa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [2:0]        operation,
	input  logic [LBL_W-1:0]  center_label,
	input  logic [VAL_W-1:0]  boundary_value,
	input  logic [LBL_W-1:0]  label_north,
	input  logic [LBL_W-1:0]  label_south,
	input  logic [LBL_W-1:0]  label_west,
	input  logic [LBL_W-1:0]  label_east,
	input  logic [LBL_W-1:0]  label_northwest,
	input  logic [LBL_W-1:0]  label_southeast,
	input  logic [LBL_W-1:0]  label_southwest,
	input  logic [LBL_W-1:0]  label_northeast,
	input  logic [11:0]       slot_index,
	output logic              done,
	output logic              status,
	output logic              entry_valid,
	output logic [LBL_W-1:0]  label_low,
	output logic [LBL_W-1:0]  label_high,
	output logic [SUM_W-1:0]  pair_sum,
	output logic [CNT_W-1:0]  pair_count
);

	state_t state_q, state_d;

	logic [TBL_AW-1:0] sweep_q;
	logic              report_q;
	logic              read_q;
	logic [3:0]        mask_q;
	logic [LBL_W-1:0]  lbl_q [8];
	logic [VAL_W-1:0]  value_q;
	logic [KEY_W-1:0]  key_q;
	logic [63:0]       prod_q;
	logic [TBL_AW-1:0] part_q;
	logic [TBL_AW-1:0] idx_q;
	logic [PRB_W-1:0]  probe_q;
	logic              drop_q;
	logic              done_q;

	// Table memory
	tbl_word_t         mem [TBL_ENTRIES];
	tbl_word_t         rdata;
	tbl_word_t         wdata;
	logic              mem_we;
	logic [TBL_AW-1:0] waddr;

	// Pair selection
	logic [1:0]       pick;
	logic [LBL_W-1:0] pa, pb;
	logic [KEY_W-1:0] key_new;
	logic             hit, sweep_end, last_probe;
	logic [SUM_W:0]   sum_ext;

	assign sweep_end  = (sweep_q == TBL_AW'(TBL_ENTRIES - 1));
	assign hit        = rdata.used && (rdata.key == key_q);
	assign last_probe = (probe_q == PRB_W'(MAX_PROBES - 1));
	assign sum_ext    = {1'b0, rdata.sum} + {{(SUM_W + 1 - VAL_W){1'b0}}, value_q};

	always_comb begin
		pick = 2'd0;
		if (mask_q[0])      pick = 2'd0;
		else if (mask_q[1]) pick = 2'd1;
		else if (mask_q[2]) pick = 2'd2;
		else                pick = 2'd3;
		pa = lbl_q[{pick, 1'b0}];
		pb = lbl_q[{pick, 1'b1}];
		key_new = (pa > pb) ? {pb, pa} : {pa, pb};
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (operation == OP_CLEAR)     state_d = ST_SWEEP;
					else if (operation == OP_READ) state_d = ST_LOOK;
					else                           state_d = ST_NEXT;
				end
			end
			ST_SWEEP: if (sweep_end) state_d = ST_IDLE;
			ST_NEXT:  state_d = (mask_q == 4'd0) ? ST_IDLE : ST_HASH1;
			ST_HASH1: state_d = ST_HASH2;
			ST_HASH2: state_d = ST_LOOK;
			ST_LOOK:  state_d = ST_CHECK;
			ST_CHECK: begin
				if (read_q)                                 state_d = ST_IDLE;
				else if (!rdata.used || hit || last_probe) state_d = ST_NEXT;
				else                                        state_d = ST_LOOK;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// Memory write port control
	always_comb begin
		mem_we = 1'b0;
		waddr  = idx_q;
		wdata  = '0;
		case (state_q)
			ST_SWEEP: begin
				mem_we = 1'b1;
				waddr  = sweep_q;
			end
			ST_CHECK: begin
				if (!read_q && !rdata.used) begin
					mem_we      = 1'b1;
					wdata.used  = 1'b1;
					wdata.key   = key_q;
					wdata.sum   = {{(SUM_W - VAL_W){1'b0}}, value_q};
					wdata.count = CNT_W'(1);
				end else if (!read_q && hit) begin
					mem_we      = 1'b1;
					wdata.used  = 1'b1;
					wdata.key   = key_q;
					wdata.sum   = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
					wdata.count = (&rdata.count) ? rdata.count : rdata.count + CNT_W'(1);
				end
			end
			default: mem_we = 1'b0;
		endcase
	end

	// Memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (mem_we) mem[waddr] <= wdata;
		rdata <= mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_SWEEP;
		else         state_q <= state_d;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q  <= '0;
			report_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= ((state_q == ST_SWEEP) && sweep_end && report_q)
				|| ((state_q == ST_NEXT) && (mask_q == 4'd0))
				|| ((state_q == ST_CHECK) && read_q);
			if (state_q == ST_SWEEP) sweep_q <= sweep_q + TBL_AW'(1);
			if (state_q == ST_IDLE && start) report_q <= 1'b1;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					read_q   <= (operation == OP_READ);
					idx_q    <= slot_index[TBL_AW-1:0];
					value_q  <= boundary_value;
					lbl_q[0] <= label_west;
					lbl_q[1] <= label_east;
					lbl_q[2] <= label_north;
					lbl_q[3] <= label_south;
					lbl_q[4] <= label_northwest;
					lbl_q[5] <= label_southeast;
					lbl_q[6] <= label_southwest;
					lbl_q[7] <= label_northeast;
					drop_q   <= 1'b0;
					if (center_label == '0) begin
						case (operation)
							OP_INTERIOR: mask_q <= 4'b1111;
							OP_ROW:      mask_q <= 4'b0001;
							OP_COLUMN:   mask_q <= 4'b0010;
							default:     mask_q <= 4'd0;
						endcase
					end else begin
						mask_q <= 4'd0;
					end
					status      <= 1'b0;
					entry_valid <= 1'b0;
					label_low   <= '0;
					label_high  <= '0;
					pair_sum    <= '0;
					pair_count  <= '0;
				end
			end
			ST_NEXT: begin
				key_q  <= key_new;
				mask_q <= mask_q & ~(4'd1 << pick);
				if (mask_q == 4'd0) status <= drop_q;
			end
			ST_HASH1: begin
				// low hash bits only need low operand bits of the cross terms
				prod_q <= {32'd0, key_q[31:0]} * {32'd0, HASH_MUL[31:0]};
				part_q <= TBL_AW'(key_q[32 +: TBL_AW] * HASH_MUL[TBL_AW-1:0])
					+ TBL_AW'(key_q[TBL_AW-1:0] * HASH_MUL[32 +: TBL_AW]);
			end
			ST_HASH2: begin
				idx_q   <= prod_q[32 +: TBL_AW] + part_q;
				probe_q <= '0;
			end
			ST_CHECK: begin
				if (read_q) begin
					if (rdata.used) begin
						entry_valid <= (rdata.key[KEY_W-1:LBL_W] != '0)
							&& (rdata.key[LBL_W-1:0] != '0);
						label_low   <= rdata.key[KEY_W-1:LBL_W];
						label_high  <= rdata.key[LBL_W-1:0];
						pair_sum    <= rdata.sum;
						pair_count  <= rdata.count;
					end
				end else if (rdata.used && !hit) begin
					if (last_probe) drop_q <= 1'b1;
					idx_q   <= idx_q + TBL_AW'(1);
					probe_q <= probe_q + PRB_W'(1);
				end
			end
			default: ;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

	// Checks
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operation == OP_CLEAR) |=> busy) else $error("clear not busy");
	a_status_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status) |-> !entry_valid) else $error("status on read");

endmodule
